@@ hdl/itrt_pkg.sv @@
// ----------------------------------------------------------------------------
// itrt_pkg
// Types, constants and the digit-to-character map of the radix text unit.
// ----------------------------------------------------------------------------
package itrt_pkg;

	localparam int unsigned BASE_W = 6;
	localparam int unsigned CHAR_W = 8;

	localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [BASE_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [BASE_W-1:0] DIGIT_TEN = 6'd10;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_READ,
		ST_EMIT
	} seq_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-BASE_W){1'b0}}, d};
		if (d >= DIGIT_TEN)
			return d_ext - {{(CHAR_W-BASE_W){1'b0}}, DIGIT_TEN} + CHAR_UPPER_A;
		else
			return d_ext + CHAR_ZERO;
	endfunction

endpackage

@@ hdl/integer_to_radix_text_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit
// Converts an unsigned integer to ASCII digits in radix 2..36, most
// significant digit first, with a flag on the final character.
// ----------------------------------------------------------------------------
//  channel | signals                  | transaction
//  --------+--------------------------+------------------------------------
//  command | start, busy, value, base | start high while busy low
//  result  | strobe, char_code, last  | one-cycle strobe per character, no stall
//
//  each digit is computed in the shared bit-serial divider, digits are
//  kept in a small RAM, then each character is read back in ST_READ and
//  sent in ST_EMIT; the next command is taken in the cycle after the last
//  character
//  busy stays high from the accepted command until the last character
//  reset clears the sequencer and divider control only
//  results cannot be held off by the receiver
// ----------------------------------------------------------------------------
module integer_to_radix_text_unit
	import itrt_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       value,
	input  logic [BASE_W-1:0] base,
	output logic              strobe,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);

	seq_state_t             state_q;
	seq_state_t             state_d;
	logic [ADDR_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]      cnt_d;
	logic [ADDR_W-1:0]      idx_q;
	logic [ADDR_W-1:0]      idx_d;
	logic [BASE_W-1:0]      radix_q;
	logic [BASE_W-1:0]      radix_clamped;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [BASE_W-1:0]      div_remainder;
	logic                   ram_wr_en;
	logic [CHAR_W-1:0]      ram_rd_data;

	always_comb begin
		if (base < RADIX_MIN)
			radix_clamped = RADIX_MIN;
		else if (base > RADIX_MAX)
			radix_clamped = RADIX_MAX;
		else
			radix_clamped = base;
	end

	itrt_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (radix_q),
		.done     (div_done),
		.quotient (div_quotient),
		.remainder(div_remainder)
	);

	itrt_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(VALUE_WIDTH)
	) u_digit_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(cnt_q),
		.wr_data(digit_char(div_remainder)),
		.rd_addr(idx_q),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			radix_q <= radix_clamped;
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		div_start    = 1'b0;
		div_dividend = div_quotient;
		ram_wr_en    = 1'b0;
		strobe       = 1'b0;
		last         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				div_dividend = value[VALUE_WIDTH-1:0];
				if (start) begin
					div_start = 1'b1;
					cnt_d     = '0;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					ram_wr_en = 1'b1;
					if (div_quotient == '0) begin
						idx_d   = cnt_q;
						state_d = ST_READ;
					end else begin
						cnt_d     = cnt_q + 1'b1;
						div_start = 1'b1;
					end
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				strobe = 1'b1;
				last   = idx_q == '0;
				if (idx_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					idx_d   = idx_q - 1'b1;
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy      = state_q != ST_IDLE;
	assign char_code = ram_rd_data;

endmodule

@@ hdl/itrt_ram.sv @@
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module itrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hdl/itrt_divider.sv @@
// ----------------------------------------------------------------------------
// itrt_divider
// Restoring bit-serial divider: one quotient bit per cycle, small remainder.
// ----------------------------------------------------------------------------
module itrt_divider
	import itrt_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [BASE_W-1:0]      divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [BASE_W-1:0]      remainder
);

	localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_WIDTH - 1);

	logic                   run_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] work_q;
	logic [BASE_W-1:0]      rem_q;
	logic [BASE_W:0]        trial;
	logic [BASE_W:0]        diff;
	logic                   ge;

	assign trial = {rem_q, work_q[VALUE_WIDTH-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (run_q) begin
			work_q <= {work_q[VALUE_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = work_q;
	assign remainder = rem_q;

endmodule
